[sv/bis_pkg.sv]
// bilinear image scaler: shared widths, codes and item types
// no dependencies; imported by every module of the scaler but bis_ram
`default_nettype none

package bis_pkg;

  localparam int POS_W       = 12;
  localparam int PIX_W       = 32;
  localparam int CH_W        = 8;
  localparam int LANES       = PIX_W / CH_W;
  localparam int SRC_DIM_W   = 9;
  localparam int DST_DIM_W   = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_W      = 16;
  localparam int STEP_W      = SRC_DIM_W + FRAC_W;
  localparam int SP_W        = POS_W + STEP_W;
  localparam int WHOLE_W     = SP_W - FRAC_W;
  localparam int WF_W        = FRAC_W + 1;
  localparam int WGT_W       = 2 * FRAC_W + 1;
  localparam int PROD_W      = CH_W + WGT_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int PIPE_LAT    = 6;

  localparam int DEF_MAX_SRC_WIDTH  = 256;
  localparam int DEF_MAX_SRC_HEIGHT = 256;
  localparam int DEF_CHANNELS       = 4;
  localparam int RST_SRC_DIM        = 256;
  localparam int RST_DST_DIM        = 256;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] src_pixel;
  } bis_in_t;

  typedef struct packed {
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [PIX_W-1:0] out_pixel;
  } bis_out_t;

  typedef struct packed {
    logic [STEP_W-1:0]    x_step;
    logic [STEP_W-1:0]    y_step;
    logic [SRC_DIM_W-1:0] x_last;
    logic [SRC_DIM_W-1:0] y_last;
  } bis_geom_t;

endpackage

`default_nettype wire

[sv/bis_ram.sv]
// generic single write port ram with registered read
// depends on nothing but its parameters
`default_nettype none

module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/bis_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// uses bis_pkg for default widths
`default_nettype none

module bis_div import bis_pkg::*; #(
  parameter int NUM_W = STEP_W,
  parameter int DEN_W = DST_DIM_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(NUM_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

[sv/bis_fifo.sv]
// short item queue between the front and back parts of the scaler
// uses bis_pkg for the item type
`default_nettype none

module bis_fifo import bis_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bis_in_t push_item,
  input  wire logic    pop,
  output bis_in_t      pop_item,
  output logic         empty,
  output logic         full
);

  localparam int PTR_W = (DEPTH < 2) ? 1 : $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bis_in_t          slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_item = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[sv/bis_front.sv]
// front part: size registers, step dividers, item accept and load range filter
// uses bis_pkg and bis_div
`default_nettype none

module bis_front import bis_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire bis_in_t              in_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 fifo_full,
  output logic                      busy,
  output logic                      push,
  output bis_in_t                   push_item,
  output bis_geom_t                 geom
);

  localparam int SW_RST = (RST_SRC_DIM > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : RST_SRC_DIM;
  localparam int SH_RST = (RST_SRC_DIM > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : RST_SRC_DIM;
  localparam int X_STEP_RST = ((SW_RST - 1) * (1 << FRAC_W)) / RST_DST_DIM;
  localparam int Y_STEP_RST = ((SH_RST - 1) * (1 << FRAC_W)) / RST_DST_DIM;

  logic [SRC_DIM_W-1:0] src_w_r;
  logic [SRC_DIM_W-1:0] src_h_r;
  logic [DST_DIM_W-1:0] dst_w_r;
  logic [DST_DIM_W-1:0] dst_h_r;
  logic                 dpend_r;
  logic [STEP_W-1:0]    x_step_r;
  logic [STEP_W-1:0]    y_step_r;

  logic [SRC_DIM_W-1:0] sw_eff;
  logic [SRC_DIM_W-1:0] sh_eff;
  logic [DST_DIM_W-1:0] dw_eff;
  logic [DST_DIM_W-1:0] dh_eff;
  logic                 divx_busy;
  logic                 divx_done;
  logic [STEP_W-1:0]    divx_quot;
  logic                 divy_busy;
  logic                 divy_done;
  logic [STEP_W-1:0]    divy_quot;
  logic                 accept;
  logic                 in_store;

  always_comb begin
    if (src_w_r == '0) begin
      sw_eff = SRC_DIM_W'(1);
    end else if (13'(src_w_r) > 13'(MAX_SRC_WIDTH)) begin
      sw_eff = SRC_DIM_W'(MAX_SRC_WIDTH);
    end else begin
      sw_eff = src_w_r;
    end
    if (src_h_r == '0) begin
      sh_eff = SRC_DIM_W'(1);
    end else if (13'(src_h_r) > 13'(MAX_SRC_HEIGHT)) begin
      sh_eff = SRC_DIM_W'(MAX_SRC_HEIGHT);
    end else begin
      sh_eff = src_h_r;
    end
    dw_eff = (dst_w_r == '0) ? DST_DIM_W'(1) : dst_w_r;
    dh_eff = (dst_h_r == '0) ? DST_DIM_W'(1) : dst_h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_DIM_W'(RST_SRC_DIM);
      src_h_r <= SRC_DIM_W'(RST_SRC_DIM);
      dst_w_r <= DST_DIM_W'(RST_DST_DIM);
      dst_h_r <= DST_DIM_W'(RST_DST_DIM);
      dpend_r <= 1'b0;
    end else begin
      dpend_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SRC_WIDTH:  src_w_r <= cfg_wdata[SRC_DIM_W-1:0];
          REG_SRC_HEIGHT: src_h_r <= cfg_wdata[SRC_DIM_W-1:0];
          REG_DST_WIDTH:  dst_w_r <= cfg_wdata[DST_DIM_W-1:0];
          REG_DST_HEIGHT: dst_h_r <= cfg_wdata[DST_DIM_W-1:0];
          default:        src_w_r <= src_w_r;
        endcase
      end
    end
  end

  bis_div #(
    .NUM_W (STEP_W),
    .DEN_W (DST_DIM_W)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dpend_r),
    .num   ({sw_eff - SRC_DIM_W'(1), FRAC_W'(0)}),
    .den   (dw_eff),
    .busy  (divx_busy),
    .done  (divx_done),
    .quot  (divx_quot)
  );

  bis_div #(
    .NUM_W (STEP_W),
    .DEN_W (DST_DIM_W)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dpend_r),
    .num   ({sh_eff - SRC_DIM_W'(1), FRAC_W'(0)}),
    .den   (dh_eff),
    .busy  (divy_busy),
    .done  (divy_done),
    .quot  (divy_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r <= STEP_W'(X_STEP_RST);
      y_step_r <= STEP_W'(Y_STEP_RST);
    end else begin
      if (divx_done) begin
        x_step_r <= divx_quot;
      end
      if (divy_done) begin
        y_step_r <= divy_quot;
      end
    end
  end

  assign busy     = dpend_r || divx_busy || divy_busy || fifo_full;
  assign accept   = start && !busy;
  assign in_store = ({1'b0, in_item.pos_x} < 13'(MAX_SRC_WIDTH)) &&
                    ({1'b0, in_item.pos_y} < 13'(MAX_SRC_HEIGHT));
  // loads outside the store are dropped here
  assign push      = accept && ((in_item.op == OP_EMIT) || in_store);
  assign push_item = in_item;

  assign geom.x_step = x_step_r;
  assign geom.y_step = y_step_r;
  assign geom.x_last = sw_eff - SRC_DIM_W'(1);
  assign geom.y_last = sh_eff - SRC_DIM_W'(1);

endmodule

`default_nettype wire

[sv/bis_back.sv]
// back part: position scaling, parity banked frame store, blend pipeline
// uses bis_pkg and bis_ram
`default_nettype none

module bis_back import bis_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
  parameter int CHANNELS       = DEF_CHANNELS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cmd_valid,
  input  wire bis_in_t   cmd,
  input  wire bis_geom_t geom,
  output logic           out_valid,
  output bis_out_t       out_item
);

  localparam int XIW = ($clog2(MAX_SRC_WIDTH) < 2) ? 2 : $clog2(MAX_SRC_WIDTH);
  localparam int YIW = ($clog2(MAX_SRC_HEIGHT) < 2) ? 2 : $clog2(MAX_SRC_HEIGHT);
  localparam int BANK_AW = (XIW - 1) + (YIW - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int V_W = ACC_W - 2 * FRAC_W;
  localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(1) << (2 * FRAC_W - 1);

  // stage 1: scaled positions
  logic             v1_r;
  logic             emit1_r;
  logic [POS_W-1:0] pos_x1_r;
  logic [POS_W-1:0] pos_y1_r;
  logic [PIX_W-1:0] pix1_r;
  logic [SP_W-1:0]  spx1_r;
  logic [SP_W-1:0]  spy1_r;
  logic [SP_W-1:0]  spx_nxt;
  logic [SP_W-1:0]  spy_nxt;

  // stage 1 decode
  logic [WHOLE_W-1:0] whole_x;
  logic [WHOLE_W-1:0] whole_y;
  logic               clamp_x;
  logic               clamp_y;
  logic [XIW-1:0]     x0;
  logic [XIW-1:0]     x1;
  logic [YIW-1:0]     y0;
  logic [YIW-1:0]     y1;

  // stage 2: store read data arrives
  logic              v2_r;
  logic [POS_W-1:0]  pos_x2_r;
  logic [POS_W-1:0]  pos_y2_r;
  logic [FRAC_W-1:0] fx2_r;
  logic [FRAC_W-1:0] fy2_r;
  logic              cx2_r;
  logic              cy2_r;
  logic              px2_r;
  logic              py2_r;
  logic [PIX_W-1:0]  rd [4];
  logic [PIX_W-1:0]  p_nxt [4];
  logic [WF_W-1:0]   fx_e;
  logic [WF_W-1:0]   fy_e;
  logic [WF_W-1:0]   gx;
  logic [WF_W-1:0]   gy;
  logic [2*WF_W-1:0] m_nxt [4];

  // stage 3: neighbors and weights
  logic             v3_r;
  logic [POS_W-1:0] pos_x3_r;
  logic [POS_W-1:0] pos_y3_r;
  logic [PIX_W-1:0] p3_r [4];
  logic [WGT_W-1:0] w3_r [4];

  // stage 4: weighted channel terms
  logic              v4_r;
  logic [POS_W-1:0]  pos_x4_r;
  logic [POS_W-1:0]  pos_y4_r;
  logic [PROD_W-1:0] prod4_r [CHANNELS][4];
  logic [PROD_W-1:0] prod_nxt [CHANNELS][4];

  logic             out_valid_r;
  bis_out_t         out_item_r;
  logic [PIX_W-1:0] pix_nxt;

  assign spx_nxt = SP_W'(cmd.pos_x) * SP_W'(geom.x_step);
  assign spy_nxt = SP_W'(cmd.pos_y) * SP_W'(geom.y_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    emit1_r  <= (cmd.op == OP_EMIT);
    pos_x1_r <= cmd.pos_x;
    pos_y1_r <= cmd.pos_y;
    pix1_r   <= cmd.src_pixel;
    spx1_r   <= spx_nxt;
    spy1_r   <= spy_nxt;
  end

  always_comb begin
    whole_x = spx1_r[SP_W-1:FRAC_W];
    whole_y = spy1_r[SP_W-1:FRAC_W];
    clamp_x = whole_x >= WHOLE_W'(geom.x_last);
    clamp_y = whole_y >= WHOLE_W'(geom.y_last);
    x0 = clamp_x ? XIW'(geom.x_last) : whole_x[XIW-1:0];
    y0 = clamp_y ? YIW'(geom.y_last) : whole_y[YIW-1:0];
    x1 = clamp_x ? x0 : x0 + XIW'(1);
    y1 = clamp_y ? y0 : y0 + YIW'(1);
  end

  // bank b holds column parity b[0] and row parity b[1]
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'((b % 2));
    localparam logic BY = 1'((b / 2));
    logic [XIW-1:0]     col;
    logic [YIW-1:0]     row;
    logic               we;
    logic [BANK_AW-1:0] waddr;
    logic [BANK_AW-1:0] raddr;

    assign col   = (x0[0] == BX) ? x0 : x1;
    assign row   = (y0[0] == BY) ? y0 : y1;
    assign raddr = {row[YIW-1:1], col[XIW-1:1]};
    assign we    = v1_r && !emit1_r && (pos_x1_r[0] == BX) && (pos_y1_r[0] == BY);
    assign waddr = {pos_y1_r[YIW-1:1], pos_x1_r[XIW-1:1]};

    bis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (pix1_r),
      .raddr (raddr),
      .rdata (rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r && emit1_r;
    end
  end

  always_ff @(posedge clk) begin
    pos_x2_r <= pos_x1_r;
    pos_y2_r <= pos_y1_r;
    fx2_r    <= spx1_r[FRAC_W-1:0];
    fy2_r    <= spy1_r[FRAC_W-1:0];
    cx2_r    <= clamp_x;
    cy2_r    <= clamp_y;
    px2_r    <= x0[0];
    py2_r    <= y0[0];
  end

  always_comb begin
    // 0: top left, 1: top right, 2: bottom left, 3: bottom right
    p_nxt[0] = rd[{py2_r, px2_r}];
    p_nxt[1] = cx2_r ? p_nxt[0] : rd[{py2_r, !px2_r}];
    p_nxt[2] = cy2_r ? p_nxt[0] : rd[{!py2_r, px2_r}];
    p_nxt[3] = cx2_r ? p_nxt[2] : (cy2_r ? p_nxt[1] : rd[{!py2_r, !px2_r}]);
    fx_e = {1'b0, fx2_r};
    fy_e = {1'b0, fy2_r};
    gx   = (WF_W'(1) << FRAC_W) - fx_e;
    gy   = (WF_W'(1) << FRAC_W) - fy_e;
    m_nxt[0] = (2*WF_W)'(gx) * (2*WF_W)'(gy);
    m_nxt[1] = (2*WF_W)'(fx_e) * (2*WF_W)'(gy);
    m_nxt[2] = (2*WF_W)'(gx) * (2*WF_W)'(fy_e);
    m_nxt[3] = (2*WF_W)'(fx_e) * (2*WF_W)'(fy_e);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    pos_x3_r <= pos_x2_r;
    pos_y3_r <= pos_y2_r;
    for (int k = 0; k < 4; k++) begin
      p3_r[k] <= p_nxt[k];
      w3_r[k] <= m_nxt[k][WGT_W-1:0];
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_prod
    for (genvar k = 0; k < 4; k++) begin : g_term
      assign prod_nxt[c][k] = PROD_W'(p3_r[k][c*CH_W +: CH_W]) * PROD_W'(w3_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pos_x4_r <= pos_x3_r;
    pos_y4_r <= pos_y3_r;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod4_r[c][k] <= prod_nxt[c][k];
      end
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      logic [ACC_W-1:0] acc;
      logic [V_W-1:0]   v;
      assign acc = ACC_W'(prod4_r[c][0]) + ACC_W'(prod4_r[c][1]) +
                   ACC_W'(prod4_r[c][2]) + ACC_W'(prod4_r[c][3]) + ROUND_C;
      assign v   = acc[ACC_W-1:2*FRAC_W];
      assign pix_nxt[c*CH_W +: CH_W] = (|v[V_W-1:CH_W]) ? '1 : v[CH_W-1:0];
    end else begin : g_unused
      assign pix_nxt[c*CH_W +: CH_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.out_x     <= pos_x4_r;
    out_item_r.out_y     <= pos_y4_r;
    out_item_r.out_pixel <= pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[sv/bilinear_image_scaler_unit.sv]
// bilinear image scaler top level: front, item queue and back part
// uses bis_pkg, bis_front, bis_fifo and bis_back
//
// load items (op load) write one packed pixel into the frame store at
// (pos_x, pos_y); loads outside the store are dropped. emit items (op emit)
// return the blended pixel for destination (pos_x, pos_y) on out_item, with
// out_valid high for exactly one cycle. an item is taken on a clock edge
// with start high and busy low.
// an emit's result passes the item queue and the stage and output registers
// of the back part. throughput: one item per clock while busy is low, loads
// and emits mixed freely; the four neighbors come from four parity banks
// read in the same cycle. a write on the cfg port restarts the per-axis
// step dividers, which hold busy high from their registered start until
// the last of the 25 quotient bits, one bit a cycle.
// a load followed by an emit that reads the same pixel sees the new value.
// the receiver cannot stall: out_item is valid only while out_valid is high.
// reset (rst_n low, synchronous) empties the queue and pipeline and sets
// all sizes to 256 with the matching steps; the frame store is not cleared.
`default_nettype none

module bilinear_image_scaler_unit import bis_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
  parameter int CHANNELS       = DEF_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bis_in_t              in_item,
  output logic                      out_valid,
  output bis_out_t                  out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic      fifo_push;
  bis_in_t   fifo_in;
  bis_in_t   fifo_out;
  logic      fifo_empty;
  logic      fifo_full;
  bis_geom_t geom;

  bis_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fifo_full (fifo_full),
    .busy      (busy),
    .push      (fifo_push),
    .push_item (fifo_in),
    .geom      (geom)
  );

  bis_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_item (fifo_in),
    .pop       (!fifo_empty),
    .pop_item  (fifo_out),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  bis_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .CHANNELS       (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!fifo_empty),
    .cmd       (fifo_out),
    .geom      (geom),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.op == OP_EMIT) |-> ##PIPE_LAT out_valid)
    else $error("emit item produced no result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a taken item");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("item taken while steps are recomputed");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_push && fifo_full))
    else $error("item pushed into a full queue");

endmodule

`default_nettype wire
